FILE: design/dtc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store of the decision-tree classifier.
// No dependencies; imported by the top level.
package dtc_pkg;

  localparam int NODES_DEF    = 256;
  localparam int FEATURES_DEF = 10;

  localparam int CMD_W   = 2;
  localparam int NIDX_W  = 8;
  localparam int NFEAT_W = 5;
  localparam int DATA_W  = 32;
  localparam int LINK_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int NODE_W  = NFEAT_W + DATA_W + 2 * LINK_W;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_NODE    = 2'd0,
    CMD_WRITE_FEATURE = 2'd1,
    CMD_CLASSIFY      = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0]        right;
    logic [LINK_W-1:0]        left;
    logic signed [DATA_W-1:0] threshold;
    logic signed [NFEAT_W-1:0] feature;
  } node_t;

  localparam int STEP_W = 1;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 1'b0;
  localparam step_t STEP_WALK = 1'b1;

  typedef enum logic [0:0] {
    COND_CLASSIFY  = 1'b0,
    COND_DONE_FREE = 1'b1
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  walk;
    cond_t cond;
    step_t target_t;
    step_t target_f;
  } uword_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE: w = '{in_ready: 1'b1, walk: 1'b0, cond: COND_CLASSIFY,
                       target_t: STEP_WALK, target_f: STEP_IDLE};
      STEP_WALK: w = '{in_ready: 1'b0, walk: 1'b1, cond: COND_DONE_FREE,
                       target_t: STEP_IDLE, target_f: STEP_WALK};
      default:   w = '{in_ready: 1'b1, walk: 1'b0, cond: COND_CLASSIFY,
                       target_t: STEP_WALK, target_f: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/dtc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/decision_tree_classifier.sv
`timescale 1ns / 1ps
// Decision-tree classifier top level: microcoded walk over a node RAM.
// Depends on dtc_pkg and dtc_ram.
//
// Write-node and write-feature beats are taken while idle. A classify beat
// starts a walk from the root that visits one node at a time, leaf
// included, until it reaches a leaf or has visited NODES + 1 nodes without
// one; the node RAM's registered read supplies each node, and its next address
// comes from the current node's compare.
// The result sits in an output register, so input beats are taken while it
// waits; a finished walk holds only if that register is still full.
// Unknown commands are consumed without a result. The node RAM has no reset.
module decision_tree_classifier #(
  parameter int NODES    = dtc_pkg::NODES_DEF,
  parameter int FEATURES = dtc_pkg::FEATURES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // node_index, node_feature, node_threshold, node_left, node_right,
  // feature_slot, feature_value, zero fill
  input  logic [dtc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command
  input  logic [dtc_pkg::CMD_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // class_label
  output logic [dtc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // exhausted
  output logic                               out_tuser
);

  import dtc_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  logic [NIDX_W-1:0]         node_index;
  logic signed [NFEAT_W-1:0] node_feature;
  logic signed [DATA_W-1:0]  node_threshold;
  logic [LINK_W-1:0]         node_left;
  logic [LINK_W-1:0]         node_right;
  logic [SLOT_W-1:0]         feature_slot;
  logic signed [DATA_W-1:0]  feature_value;

  assign node_index     = in_tdata[7:0];
  assign node_feature   = in_tdata[12:8];
  assign node_threshold = in_tdata[44:13];
  assign node_left      = in_tdata[52:45];
  assign node_right     = in_tdata[60:53];
  assign feature_slot   = in_tdata[64:61];
  assign feature_value  = in_tdata[96:65];

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   in_beat;
  logic   cond_hit;

  logic [AW-1:0] cur_addr_r, cur_addr_nxt;
  logic          cur_oor_r, cur_oor_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                     out_valid_r;
  logic [LINK_W-1:0]        out_label_r;
  logic                     out_exh_r;

  logic signed [DATA_W-1:0] feat_r [FEATURES];

  logic                     ram_we;
  node_t                    ram_wdata;
  node_t                    ram_rdata;
  logic [AW-1:0]            rd_addr;
  node_t                    cur;
  logic                     leaf;
  logic                     last_visit;
  logic                     done;
  logic                     fire;
  logic signed [DATA_W-1:0] fval;
  logic                     go_left;
  logic [LINK_W-1:0]        next_node;

  assign uw        = ucode(pc_r);
  assign in_tready = uw.in_ready;
  assign in_beat   = in_tvalid && in_tready;

  // current node; a link beyond the store reads as all-zero fields
  assign cur        = cur_oor_r ? node_t'('0) : ram_rdata;
  assign leaf       = cur.feature[NFEAT_W-1];
  assign last_visit = (cnt_r == CW'(NODES));
  assign done       = uw.walk && (leaf || last_visit);
  assign fire       = done && (!out_valid_r || out_tready);

  always_comb begin
    fval = '0;
    if (!cur.feature[NFEAT_W-1] && (32'(cur.feature[NFEAT_W-2:0]) < 32'(FEATURES))) begin
      fval = feat_r[FW'(cur.feature[NFEAT_W-2:0])];
    end
  end

  assign go_left   = (fval <= cur.threshold);
  assign next_node = go_left ? cur.left : cur.right;

  always_comb begin
    case (uw.cond)
      COND_CLASSIFY:  cond_hit = in_beat && (in_tuser == CMD_CLASSIFY);
      COND_DONE_FREE: cond_hit = fire;
      default:        cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.target_t : uw.target_f;
  end

  // root on entry, next node while walking, hold while the result waits
  always_comb begin
    cur_addr_nxt = '0;
    cur_oor_nxt  = 1'b0;
    cnt_nxt      = '0;
    if (uw.walk) begin
      if (!done) begin
        cur_addr_nxt = AW'(next_node);
        cur_oor_nxt  = (32'(next_node) >= 32'(NODES));
        cnt_nxt      = cnt_r + CW'(1);
      end else begin
        cur_addr_nxt = cur_addr_r;
        cur_oor_nxt  = cur_oor_r;
        cnt_nxt      = cnt_r;
      end
    end
  end

  assign rd_addr = cur_addr_nxt;

  assign ram_we    = in_beat && (in_tuser == CMD_WRITE_NODE) &&
                     (32'(node_index) < 32'(NODES));
  assign ram_wdata = '{right: node_right, left: node_left,
                       threshold: node_threshold, feature: node_feature};

  dtc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(node_index)),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= STEP_IDLE;
      cnt_r      <= '0;
      cur_addr_r <= '0;
      cur_oor_r  <= 1'b0;
    end else begin
      pc_r       <= pc_nxt;
      cnt_r      <= cnt_nxt;
      cur_addr_r <= cur_addr_nxt;
      cur_oor_r  <= cur_oor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEATURES; i++) begin
        feat_r[i] <= '0;
      end
    end else if (in_beat && (in_tuser == CMD_WRITE_FEATURE) &&
                 (32'(feature_slot) < 32'(FEATURES))) begin
      feat_r[FW'(feature_slot)] <= feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_label_r <= leaf ? cur.left : '0;
      out_exh_r   <= !leaf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_label_r;
  assign out_tuser  = out_exh_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NODES))
    else $error("visit count beyond limit");

  a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_tuser == CMD_CLASSIFY) |=> (pc_r == STEP_WALK) && (cnt_r == '0))
    else $error("classify beat did not start a walk at the root");

  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == STEP_WALK)
    else $error("result raised outside a walk");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exh_r |-> out_label_r == '0)
    else $error("exhausted result with non-zero class");

  a_walk_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (pc_r == STEP_IDLE) && out_valid_r)
    else $error("finished walk did not post its result");
`endif

endmodule

FILE: bench/decision_tree_classifier_test.sv
`timescale 1ns / 1ps
// Self-checking bench for decision_tree_classifier: loads trees and features,
// predicts every classify walk and checks each out beat against it.
// Depends on dtc_pkg and the decision_tree_classifier RTL.
module decision_tree_classifier_test;
  import dtc_pkg::*;

  localparam int NODES        = NODES_DEF;
  localparam int FEATURES     = FEATURES_DEF;
  localparam int RANDOM_BEATS = 800;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [6:0]                fill;
    logic signed [DATA_W-1:0]  feature_value;
    logic [SLOT_W-1:0]         feature_slot;
    logic [LINK_W-1:0]         node_right;
    logic [LINK_W-1:0]         node_left;
    logic signed [DATA_W-1:0]  node_threshold;
    logic signed [NFEAT_W-1:0] node_feature;
    logic [NIDX_W-1:0]         node_index;
  } beat_t;

  typedef struct {
    logic [LINK_W-1:0] label;
    logic              exhausted;
  } class_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  logic signed [NFEAT_W-1:0] tree_feature   [NODES];
  logic signed [DATA_W-1:0]  tree_threshold [NODES];
  logic [LINK_W-1:0]         tree_left      [NODES];
  logic [LINK_W-1:0]         tree_right     [NODES];
  bit                        tree_written   [NODES];
  logic signed [DATA_W-1:0]  feature_reg    [FEATURES];

  class_t expected_class_q[$];

  int  errors        = 0;
  int  beats_sent    = 0;
  int  classes_seen  = 0;
  int  exhausted_cnt = 0;
  int  deepest_walk  = 0;
  int  cycle_count   = 0;
  int  stall_left    = 0;
  int  stall_draw;
  bit  idle_enabled  = 1'b1;
  bit  deep_links    = 1'b0;
  int  leaf_pct      = 35;

  decision_tree_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'sh8000_0000;
    if (r < 20) return 32'sh7fff_ffff;
    if (r < 25) return '0;
    if (r < 30) return -32'sd1;
    return $urandom;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b = beat_t'({$urandom, $urandom, $urandom, 8'($urandom)});
    b.fill = '0;
    return b;
  endfunction

  // walk the predicted tree from node 0; flag the first unwritten node met
  function automatic void classify_walk(output class_t res, output int visits,
                                        output int unwritten);
    logic [LINK_W-1:0]        n;
    logic signed [DATA_W-1:0] val;
    n = '0;
    res.label = '0;
    res.exhausted = 1'b1;
    visits = 0;
    unwritten = -1;
    for (int step = 0; step <= NODES; step++) begin
      if (!tree_written[n]) begin
        unwritten = int'(n);
        return;
      end
      visits++;
      if (tree_feature[n] < 0) begin
        res.label = tree_left[n];
        res.exhausted = 1'b0;
        return;
      end
      val = (tree_feature[n] < FEATURES) ? feature_reg[tree_feature[n]] : 32'sd0;
      n = (val <= tree_threshold[n]) ? tree_left[n] : tree_right[n];
    end
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input beat_t b);
    int     gap;
    int     visits;
    int     unwritten;
    class_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    case (cmd)
      CMD_WRITE_NODE: begin
        tree_feature[b.node_index]   = b.node_feature;
        tree_threshold[b.node_index] = b.node_threshold;
        tree_left[b.node_index]      = b.node_left;
        tree_right[b.node_index]     = b.node_right;
        tree_written[b.node_index]   = 1'b1;
      end
      CMD_WRITE_FEATURE: begin
        if (b.feature_slot < FEATURES) feature_reg[b.feature_slot] = b.feature_value;
      end
      CMD_CLASSIFY: begin
        classify_walk(res, visits, unwritten);
        expected_class_q.insert(expected_class_q.size(), res);
        if (res.exhausted) exhausted_cnt++;
        if (visits > deepest_walk) deepest_walk = visits;
      end
      default: ;
    endcase
  endtask

  task automatic write_node(input int idx, input int feat, input logic [31:0] thr,
                            input int lft, input int rgt);
    beat_t b;
    b = random_beat();
    b.node_index     = NIDX_W'(idx);
    b.node_feature   = NFEAT_W'(feat);
    b.node_threshold = thr;
    b.node_left      = LINK_W'(lft);
    b.node_right     = LINK_W'(rgt);
    send_beat(CMD_WRITE_NODE, b);
  endtask

  task automatic write_feature(input int slot, input logic [31:0] val);
    beat_t b;
    b = random_beat();
    b.feature_slot  = SLOT_W'(slot);
    b.feature_value = val;
    send_beat(CMD_WRITE_FEATURE, b);
  endtask

  task automatic write_random_node(input int idx);
    beat_t b;
    int    r;
    b = random_beat();
    b.node_index = NIDX_W'(idx);
    r = $urandom_range(0, 99);
    if (r < leaf_pct) b.node_feature = 5'(32 - $urandom_range(1, 16));
    else if (r < 93) b.node_feature = NFEAT_W'($urandom_range(0, FEATURES - 1));
    else b.node_feature = NFEAT_W'($urandom_range(FEATURES, 15));
    b.node_threshold = rand_word();
    if (deep_links) begin
      b.node_left  = LINK_W'(idx + $urandom_range(1, 8));
      b.node_right = LINK_W'(idx + $urandom_range(1, 8));
    end
    send_beat(CMD_WRITE_NODE, b);
  endtask

  // fill in any unwritten node on the path before classifying
  task automatic classify_safely();
    class_t res;
    int     visits;
    int     unwritten;
    classify_walk(res, visits, unwritten);
    while (unwritten >= 0) begin
      write_random_node(unwritten);
      classify_walk(res, visits, unwritten);
    end
    send_beat(CMD_CLASSIFY, random_beat());
  endtask

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (expected_class_q.size() == 0) begin
        $display("%0t: unexpected out beat: label %0d exhausted %0b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        classes_seen++;
        if (out_tdata !== expected_class_q[0].label) begin
          $display("%0t: class_label mismatch: expected %0d, actual %0d",
                   $time, expected_class_q[0].label, out_tdata);
          errors++;
        end
        if (out_tuser !== expected_class_q[0].exhausted) begin
          $display("%0t: exhausted mismatch: expected %0b, actual %0b",
                   $time, expected_class_q[0].exhausted, out_tuser);
          errors++;
        end
        void'(expected_class_q.pop_front());
      end
    end
    if (!idle_enabled) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_draw = pick_gap();
      out_tready <= (stall_draw == 0);
      stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end
  end

  task automatic test_leaf_labels();
    write_node(0, -16, 32'h0, 255, 0);
    classify_safely();
    write_node(0, -1, 32'h7fff_ffff, 0, 255);
    classify_safely();
    send_beat(CMD_UNUSED, random_beat());
  endtask

  task automatic test_feature_compare();
    write_feature(9, 32'h8000_0000);
    write_feature(15, 32'h7fff_ffff);
    write_node(1, -1, 32'h0, 11, 0);
    write_node(2, -1, 32'h0, 22, 0);
    write_node(0, 9, 32'h8000_0000, 1, 2);
    classify_safely();
    write_feature(9, 32'h7fff_ffff);
    classify_safely();
    write_feature(10, 32'h1234_5678);
    write_node(0, 15, 32'h0, 1, 2);
    classify_safely();
    write_node(0, 12, 32'hffff_ffff, 1, 2);
    classify_safely();
  endtask

  task automatic test_walk_exhausted();
    write_feature(0, 32'h0);
    write_node(0, 0, 32'h7fff_ffff, 0, 0);
    classify_safely();
    write_node(255, -8, 32'h0, 200, 0);
    write_node(0, 0, 32'h8000_0000, 0, 255);
    classify_safely();
  endtask

  task automatic test_random_trees();
    int r;
    while (beats_sent < RANDOM_BEATS + 25) begin
      idle_enabled = ($urandom_range(0, 4) != 0);
      deep_links   = 1'($urandom_range(0, 1));
      leaf_pct     = deep_links ? 10 : 35;
      write_random_node(0);
      repeat ($urandom_range(0, 6)) write_random_node($urandom_range(0, NODES - 1));
      repeat ($urandom_range(1, 4)) write_feature($urandom_range(0, 15), rand_word());
      repeat ($urandom_range(4, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 15) write_feature($urandom_range(0, FEATURES - 1), rand_word());
        else if (r < 18) write_feature($urandom_range(FEATURES, 15), rand_word());
        else if (r < 21) send_beat(CMD_UNUSED, random_beat());
        else if (r < 26) write_random_node($urandom_range(0, NODES - 1));
        else classify_safely();
      end
    end
  endtask

  initial begin
    foreach (tree_written[i]) tree_written[i] = 1'b0;
    foreach (feature_reg[i]) feature_reg[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_enabled = 1'b0;
    test_leaf_labels();
    idle_enabled = 1'b1;
    test_feature_compare();
    test_walk_exhausted();
    test_random_trees();
    in_tvalid <= 1'b0;
    while (expected_class_q.size() != 0) @(posedge clk);
    repeat (NODES + 8) @(posedge clk);
    $display("Sent %0d beats; checked %0d classifications, %0d of them exhausted walks.",
             beats_sent, classes_seen, exhausted_cnt);
    $display("Longest walk visited %0d nodes; %0d mismatches.", deepest_walk, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
